// File: sv/ski_pkg.sv
// Package for the sorted key index: widths, codes, entry and memory request types.
// Used by every file of the block; depends on nothing.
package ski_pkg;

   localparam int CAPACITY   = 1024;
   localparam int ADDR_W     = $clog2(CAPACITY);
   localparam int COUNT_W    = $clog2(CAPACITY + 1);
   localparam int KEY_HIGH_W = 24;
   localparam int KEY_LOW_W  = 64;
   localparam int KEY_W      = KEY_HIGH_W + KEY_LOW_W;
   localparam int POS_W      = 31;
   localparam int STATUS_W   = 2;

   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_LOOKUP = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_DONE = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_MISS = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd2;

   typedef enum logic [2:0] {
      S_IDLE,
      S_PROBE,
      S_COMPARE,
      S_SHIFT_RD,
      S_SHIFT_WR,
      S_PLACE,
      S_DONE
   } state_type;

   typedef struct packed {
      logic [KEY_HIGH_W-1:0] key_high;
      logic [KEY_LOW_W-1:0]  key_low;
      logic [POS_W-1:0]      position;
   } entry_type;

   typedef struct packed {
      logic             wr_en;
      logic [ADDR_W-1:0] wr_addr;
      entry_type         wr_data;
      logic [ADDR_W-1:0] rd_addr;
   } mem_req_type;

endpackage

// File: sv/ski_ifs.sv
// Valid/ready channel interfaces for the sorted key index request and response beats.
// Depends on ski_pkg for the field widths.
interface ski_req_if;
   logic                             valid;
   logic                             ready;
   logic                             opcode;
   logic [ski_pkg::KEY_HIGH_W-1:0]   key_high;
   logic [ski_pkg::KEY_LOW_W-1:0]    key_low;
   logic [ski_pkg::POS_W-1:0]        record_position;

   modport source (output valid, opcode, key_high, key_low, record_position, input ready);
   modport sink   (input valid, opcode, key_high, key_low, record_position, output ready);
endinterface

interface ski_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [ski_pkg::STATUS_W-1:0]   status;
   logic [ski_pkg::POS_W-1:0]      found_position;

   modport source (output valid, status, found_position, input ready);
   modport sink   (input valid, status, found_position, output ready);
endinterface

// File: sv/ski_store.sv
// Entry memory of the sorted key index: one write port, one read port, registered read data.
// Depends on ski_pkg for the entry and request types.
module ski_store (
   input  logic                 clock,
   input  ski_pkg::mem_req_type mem_req,
   output ski_pkg::entry_type   rd_data
);

   ski_pkg::entry_type mem [ski_pkg::CAPACITY];
   ski_pkg::entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         mem[mem_req.wr_addr] <= mem_req.wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[mem_req.rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: sv/sorted_key_index.sv
// Sorted key index. Keys of 88 bits are kept in ascending order in a single-port-read
// memory of ski_pkg::CAPACITY entries together with their record positions. Every request
// beat gives exactly one response beat. The block takes one request at a time: a lookup is
// a binary search over the one memory read port, each probe a read state and a compare
// state. An insert runs the same search to find the slot after any equal keys, then moves
// every later entry up by one, each with a read and a write state, and writes the new
// entry. An insert into a full table answers table full without a search. A finished
// response waits in an output register while the next request is taken. The table is
// empty after reset.
module sorted_key_index (
   input  logic       clock,
   input  logic       reset,
   ski_req_if.sink    req_chan,
   ski_rsp_if.source  rsp_chan
);

   localparam int CW = ski_pkg::COUNT_W;
   localparam int AW = ski_pkg::ADDR_W;

   ski_pkg::state_type state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] lo_ff, lo_in;
   logic [CW-1:0] hp1_ff, hp1_in;   // upper search bound plus one
   logic [CW-1:0] j_ff, j_in;
   logic          op_ff, op_in;
   logic [ski_pkg::KEY_W-1:0] key_ff, key_in;
   logic [ski_pkg::POS_W-1:0] pos_ff, pos_in;
   logic [ski_pkg::STATUS_W-1:0] status_ff, status_in;
   logic [ski_pkg::POS_W-1:0] found_ff, found_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [ski_pkg::STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [ski_pkg::POS_W-1:0] rsp_pos_ff, rsp_pos_in;

   ski_pkg::mem_req_type mem_req;
   ski_pkg::entry_type   rd_data;

   logic          req_ready;
   logic [CW-1:0] diff;
   logic [CW-1:0] mid;
   logic [CW-1:0] lo_next, hp1_next;
   logic [CW-1:0] j_dec;
   logic [ski_pkg::KEY_W-1:0] mem_key;
   logic          key_lt, key_eq;

   ski_store u_store (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

   // Shared search datapath: midpoint rounded down and one wide key compare.
   assign diff    = hp1_ff - lo_ff - CW'(1);
   assign mid     = lo_ff + (diff >> 1);
   assign mem_key = {rd_data.key_high, rd_data.key_low};
   assign key_lt  = key_ff < mem_key;
   assign key_eq  = key_ff == mem_key;
   assign lo_next  = key_lt ? lo_ff : mid + CW'(1);
   assign hp1_next = key_lt ? mid : hp1_ff;
   assign j_dec    = j_ff - CW'(1);

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      lo_in         = lo_ff;
      hp1_in        = hp1_ff;
      j_in          = j_ff;
      op_in         = op_ff;
      key_in        = key_ff;
      pos_in        = pos_ff;
      status_in     = status_ff;
      found_in      = found_ff;
      rsp_valid_in  = rsp_valid_ff & ~rsp_chan.ready;
      rsp_status_in = rsp_status_ff;
      rsp_pos_in    = rsp_pos_ff;
      req_ready     = 1'b0;
      mem_req       = '0;

      case (state_ff)
         ski_pkg::S_IDLE: begin
            req_ready = 1'b1;
            if (req_chan.valid) begin
               op_in    = req_chan.opcode;
               key_in   = {req_chan.key_high, req_chan.key_low};
               pos_in   = req_chan.record_position;
               lo_in    = '0;
               hp1_in   = count_ff;
               j_in     = count_ff;
               found_in = '0;
               if (req_chan.opcode == ski_pkg::OP_INSERT
                   && count_ff == CW'(ski_pkg::CAPACITY)) begin
                  status_in = ski_pkg::STATUS_FULL;
                  state_in  = ski_pkg::S_DONE;
               end else if (count_ff == '0) begin
                  if (req_chan.opcode == ski_pkg::OP_INSERT) begin
                     state_in = ski_pkg::S_PLACE;
                  end else begin
                     status_in = ski_pkg::STATUS_MISS;
                     state_in  = ski_pkg::S_DONE;
                  end
               end else begin
                  state_in = ski_pkg::S_PROBE;
               end
            end
         end
         ski_pkg::S_PROBE: begin
            mem_req.rd_addr = mid[AW-1:0];
            state_in        = ski_pkg::S_COMPARE;
         end
         ski_pkg::S_COMPARE: begin
            if (op_ff == ski_pkg::OP_LOOKUP && key_eq) begin
               status_in = ski_pkg::STATUS_DONE;
               found_in  = rd_data.position;
               state_in  = ski_pkg::S_DONE;
            end else begin
               lo_in  = lo_next;
               hp1_in = hp1_next;
               if (lo_next < hp1_next) begin
                  state_in = ski_pkg::S_PROBE;
               end else if (op_ff == ski_pkg::OP_LOOKUP) begin
                  status_in = ski_pkg::STATUS_MISS;
                  state_in  = ski_pkg::S_DONE;
               end else if (j_ff > lo_next) begin
                  state_in = ski_pkg::S_SHIFT_RD;
               end else begin
                  state_in = ski_pkg::S_PLACE;
               end
            end
         end
         ski_pkg::S_SHIFT_RD: begin
            mem_req.rd_addr = j_dec[AW-1:0];
            state_in        = ski_pkg::S_SHIFT_WR;
         end
         ski_pkg::S_SHIFT_WR: begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = j_ff[AW-1:0];
            mem_req.wr_data = rd_data;
            j_in            = j_dec;
            state_in        = (j_dec > lo_ff) ? ski_pkg::S_SHIFT_RD : ski_pkg::S_PLACE;
         end
         ski_pkg::S_PLACE: begin
            // The slot is the first entry whose key is strictly above the new key.
            mem_req.wr_en            = 1'b1;
            mem_req.wr_addr          = lo_ff[AW-1:0];
            mem_req.wr_data.key_high = key_ff[ski_pkg::KEY_W-1:ski_pkg::KEY_LOW_W];
            mem_req.wr_data.key_low  = key_ff[ski_pkg::KEY_LOW_W-1:0];
            mem_req.wr_data.position = pos_ff;
            count_in                 = count_ff + CW'(1);
            status_in                = ski_pkg::STATUS_DONE;
            state_in                 = ski_pkg::S_DONE;
         end
         ski_pkg::S_DONE: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_pos_in    = found_ff;
               state_in      = ski_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = ski_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ski_pkg::S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      lo_ff         <= lo_in;
      hp1_ff        <= hp1_in;
      j_ff          <= j_in;
      op_ff         <= op_in;
      key_ff        <= key_in;
      pos_ff        <= pos_in;
      status_ff     <= status_in;
      found_ff      <= found_in;
      rsp_status_ff <= rsp_status_in;
      rsp_pos_ff    <= rsp_pos_in;
   end

   assign req_chan.ready          = req_ready;
   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.status         = rsp_status_ff;
   assign rsp_chan.found_position = rsp_pos_ff;

endmodule

// File: sv/ski_checker.sv
// Port-level checker for the sorted key index, bound to the top level.
// Depends on ski_pkg for widths and status codes.
module ski_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_valid,
   input logic                           req_ready,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input logic [ski_pkg::STATUS_W-1:0]   rsp_status,
   input logic [ski_pkg::POS_W-1:0]      rsp_found_position
);

   logic [1:0] pending_ff, pending_in;
   logic       req_beat, rsp_beat;

   assign req_beat = req_valid & req_ready;
   assign rsp_beat = rsp_valid & rsp_ready;

   // Requests accepted whose response beat has not gone out yet.
   always_comb begin
      pending_in = pending_ff;
      if (req_beat && !rsp_beat) begin
         pending_in = pending_ff + 2'd1;
      end else if (!req_beat && rsp_beat) begin
         pending_in = pending_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pending_ff != 2'd0)
      else $error("response offered without an outstanding request");

   assert property (@(posedge clock) disable iff (reset)
      req_beat |-> pending_ff <= 2'd1)
      else $error("request taken while more than one response is owed");

   assert property (@(posedge clock) disable iff (reset)
      req_beat |=> !req_ready)
      else $error("request side ready right after taking a beat");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status == ski_pkg::STATUS_DONE
                     || rsp_status == ski_pkg::STATUS_MISS
                     || rsp_status == ski_pkg::STATUS_FULL))
      else $error("response status code out of range");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ski_pkg::STATUS_DONE |-> rsp_found_position == '0)
      else $error("nonzero position on a response that is not a hit");

endmodule

bind sorted_key_index ski_checker u_ski_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_chan.valid),
   .req_ready          (req_chan.ready),
   .rsp_valid          (rsp_chan.valid),
   .rsp_ready          (rsp_chan.ready),
   .rsp_status         (rsp_chan.status),
   .rsp_found_position (rsp_chan.found_position)
);

// File: test/tb.sv
// Testbench for sorted_key_index: directed and random insert and lookup beats, with
// answers checked against typed values or an in-bench sorted table (binary search for lookups).
// Depends on ski_pkg and the ski_req_if and ski_rsp_if interfaces.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int DRAIN_CYCLES   = 2 * ski_pkg::CAPACITY + 100;
   localparam logic ANSWER_TYPED     = 1'b1;
   localparam logic ANSWER_PREDICTED = 1'b0;

   typedef struct packed {
      logic                           opcode;
      logic [ski_pkg::KEY_HIGH_W-1:0] key_high;
      logic [ski_pkg::KEY_LOW_W-1:0]  key_low;
      logic [ski_pkg::POS_W-1:0]      position;
   } index_request_type;

   typedef struct packed {
      logic [ski_pkg::STATUS_W-1:0] status;
      logic [ski_pkg::POS_W-1:0]    found_position;
   } index_answer_type;

   typedef struct packed {
      index_request_type request;
      logic              typed;
      index_answer_type  answer;
   } directed_row_type;

   logic clock;
   logic reset;

   ski_req_if req_bus ();
   ski_rsp_if rsp_bus ();

   sorted_key_index i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   // Mirror of the sorted table.
   logic [ski_pkg::KEY_HIGH_W-1:0] table_high [ski_pkg::CAPACITY];
   logic [ski_pkg::KEY_LOW_W-1:0]  table_low  [ski_pkg::CAPACITY];
   logic [ski_pkg::POS_W-1:0]      table_pos  [ski_pkg::CAPACITY];
   int                             table_count = 0;

   logic [ski_pkg::KEY_W-1:0] stored_keys [$];
   index_answer_type          answers_due [$];

   int send_gap_pct = 0;
   int stall_pct    = 0;
   int error_count  = 0;
   int quiet_cycles = 0;
   int fill_index   = 0;
   int n_stored = 0, n_refused = 0, n_hits = 0, n_misses = 0, n_answers = 0;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Applies one request to the mirror table and returns the answer it must produce.
   function automatic index_answer_type predict_answer(input index_request_type r);
      index_answer_type          a;
      logic [ski_pkg::KEY_W-1:0] key;
      int                        slot, lo, hi, mid;
      a.status         = ski_pkg::STATUS_DONE;
      a.found_position = '0;
      key              = {r.key_high, r.key_low};
      if (r.opcode == ski_pkg::OP_INSERT) begin
         if (table_count >= ski_pkg::CAPACITY) begin
            a.status = ski_pkg::STATUS_FULL;
         end else begin
            // New keys land after every equal key.
            slot = table_count;
            for (int j = 0; j < table_count; j++) begin
               if (key < {table_high[j], table_low[j]}) begin
                  slot = j;
                  break;
               end
            end
            for (int j = table_count; j > slot; j--) begin
               table_high[j] = table_high[j-1];
               table_low[j]  = table_low[j-1];
               table_pos[j]  = table_pos[j-1];
            end
            table_high[slot] = r.key_high;
            table_low[slot]  = r.key_low;
            table_pos[slot]  = r.position;
            table_count++;
         end
      end else begin
         a.status = ski_pkg::STATUS_MISS;
         lo = 0;
         hi = table_count - 1;
         while (lo <= hi) begin
            mid = lo + (hi - lo) / 2;
            if (key == {table_high[mid], table_low[mid]}) begin
               a.status         = ski_pkg::STATUS_DONE;
               a.found_position = table_pos[mid];
               break;
            end else if (key < {table_high[mid], table_low[mid]}) begin
               hi = mid - 1;
            end else begin
               lo = mid + 1;
            end
         end
      end
      return a;
   endfunction

   // Mixed traffic: keys are fresh, reused or one off a stored key, so that
   // lookups hit and miss and inserts land among duplicates.
   function automatic index_request_type random_request();
      index_request_type         r;
      logic [ski_pkg::KEY_W-1:0] key;
      int                        pick;
      r.opcode   = ($urandom_range(99) < 45) ? ski_pkg::OP_INSERT : ski_pkg::OP_LOOKUP;
      r.position = 31'($urandom);
      pick       = $urandom_range(99);
      if (stored_keys.size() == 0
          || pick < ((r.opcode == ski_pkg::OP_INSERT) ? 60 : 30)) begin
         key = {24'($urandom_range(24'hEFFFFF)), $urandom, $urandom};
      end else begin
         key = stored_keys[$urandom_range(stored_keys.size() - 1)];
         if (pick >= 90) key = key + 1'b1;
         else if (pick >= 80) key = key - 1'b1;
      end
      {r.key_high, r.key_low} = key;
      return r;
   endfunction

   task automatic send_request(input index_request_type r, input logic typed,
                               input index_answer_type given);
      index_answer_type predicted;
      while ($urandom_range(99) < send_gap_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid           <= 1'b1;
      req_bus.opcode          <= r.opcode;
      req_bus.key_high        <= r.key_high;
      req_bus.key_low         <= r.key_low;
      req_bus.record_position <= r.position;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      predicted = predict_answer(r);
      answers_due.push_back(typed ? given : predicted);
      case (predicted.status)
         ski_pkg::STATUS_FULL: n_refused++;
         ski_pkg::STATUS_MISS: n_misses++;
         default: begin
            if (r.opcode == ski_pkg::OP_INSERT) begin
               n_stored++;
               stored_keys.push_back({r.key_high, r.key_low});
            end else begin
               n_hits++;
            end
         end
      endcase
   endtask

   task automatic settle();
      req_bus.valid <= 1'b0;
      while (answers_due.size() != 0) @(posedge clock);
   endtask

   task automatic run_phase(input int gap_pct, input int hold_pct, input bit fill_first,
                            input int mixed_items);
      send_gap_pct = gap_pct;
      stall_pct    = hold_pct;
      // Ascending keys go in near the top of the table, so filling it stays cheap.
      if (fill_first) begin
         while (table_count < ski_pkg::CAPACITY) begin
            send_request({ski_pkg::OP_INSERT, 24'hF00000 + 24'(fill_index),
                          {$urandom, $urandom}, 31'($urandom)}, ANSWER_PREDICTED, '0);
            fill_index++;
         end
      end
      repeat (mixed_items) send_request(random_request(), ANSWER_PREDICTED, '0);
      settle();
   endtask

   // Response side: random stalls and the check of every answer beat.
   initial begin
      index_answer_type want;
      rsp_bus.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_bus.valid && rsp_bus.ready) begin
            n_answers++;
            if (answers_due.size() == 0) begin
               error_count++;
               $display("%0t: answer beat with none outstanding: status %0d position %0h",
                        $time, rsp_bus.status, rsp_bus.found_position);
            end else begin
               want = answers_due.pop_front();
               if (rsp_bus.status !== want.status) begin
                  error_count++;
                  $display("%0t: status expected %0d, got %0d",
                           $time, want.status, rsp_bus.status);
               end
               if (rsp_bus.found_position !== want.found_position) begin
                  error_count++;
                  $display("%0t: found_position expected %0h, got %0h",
                           $time, want.found_position, rsp_bus.found_position);
               end
            end
         end
         rsp_bus.ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no beat on either channel for %0d cycles", $time, quiet_cycles);
         $display("FAILURE");
         $finish;
      end
   end

   initial begin
      directed_row_type directed_rows [$];
      reset                   = 1'b1;
      req_bus.valid           = 1'b0;
      req_bus.opcode          = ski_pkg::OP_INSERT;
      req_bus.key_high        = '0;
      req_bus.key_low         = '0;
      req_bus.record_position = '0;

      // Empty table, extreme keys and positions, boundaries across the two key
      // fields, string keys and a run of duplicates.
      directed_rows.push_back({ski_pkg::OP_LOOKUP, 24'h000000, 64'h0, 31'h0,
                               ANSWER_TYPED, ski_pkg::STATUS_MISS, 31'h0});
      directed_rows.push_back({ski_pkg::OP_LOOKUP, 24'hFFFFFF, {64{1'b1}}, 31'h0,
                               ANSWER_TYPED, ski_pkg::STATUS_MISS, 31'h0});
      directed_rows.push_back({ski_pkg::OP_INSERT, 24'h000000, 64'h0, 31'h0,
                               ANSWER_TYPED, ski_pkg::STATUS_DONE, 31'h0});
      directed_rows.push_back({ski_pkg::OP_INSERT, 24'hFFFFFF, {64{1'b1}}, 31'h7FFFFFFF,
                               ANSWER_TYPED, ski_pkg::STATUS_DONE, 31'h0});
      directed_rows.push_back({ski_pkg::OP_LOOKUP, 24'h000000, 64'h0, 31'h7FFFFFFF,
                               ANSWER_TYPED, ski_pkg::STATUS_DONE, 31'h0});
      directed_rows.push_back({ski_pkg::OP_LOOKUP, 24'hFFFFFF, {64{1'b1}}, 31'h0,
                               ANSWER_TYPED, ski_pkg::STATUS_DONE, 31'h7FFFFFFF});
      directed_rows.push_back({ski_pkg::OP_INSERT, 24'h000000, {64{1'b1}}, 31'h1,
                               ANSWER_TYPED, ski_pkg::STATUS_DONE, 31'h0});
      directed_rows.push_back({ski_pkg::OP_INSERT, 24'h000001, 64'h0, 31'h2,
                               ANSWER_TYPED, ski_pkg::STATUS_DONE, 31'h0});
      directed_rows.push_back({ski_pkg::OP_LOOKUP, 24'h000000, {64{1'b1}}, 31'h0,
                               ANSWER_PREDICTED, ski_pkg::STATUS_DONE, 31'h0});
      directed_rows.push_back({ski_pkg::OP_LOOKUP, 24'h000000, 64'hFFFFFFFFFFFFFFFE, 31'h0,
                               ANSWER_PREDICTED, ski_pkg::STATUS_DONE, 31'h0});
      directed_rows.push_back({ski_pkg::OP_LOOKUP, 24'h000001, 64'h0, 31'h0,
                               ANSWER_PREDICTED, ski_pkg::STATUS_DONE, 31'h0});
      directed_rows.push_back({ski_pkg::OP_INSERT, "KEY", "00000001", 31'd10,
                               ANSWER_PREDICTED, ski_pkg::STATUS_DONE, 31'h0});
      directed_rows.push_back({ski_pkg::OP_INSERT, "KEY", "00000001", 31'd20,
                               ANSWER_PREDICTED, ski_pkg::STATUS_DONE, 31'h0});
      directed_rows.push_back({ski_pkg::OP_INSERT, "KEY", "00000001", 31'd30,
                               ANSWER_PREDICTED, ski_pkg::STATUS_DONE, 31'h0});
      directed_rows.push_back({ski_pkg::OP_LOOKUP, "KEY", "00000001", 31'h0,
                               ANSWER_PREDICTED, ski_pkg::STATUS_DONE, 31'h0});
      directed_rows.push_back({ski_pkg::OP_INSERT, {"AB", 8'h00}, 64'h0, 31'h2AAAAAAA,
                               ANSWER_PREDICTED, ski_pkg::STATUS_DONE, 31'h0});
      directed_rows.push_back({ski_pkg::OP_LOOKUP, {"AB", 8'h00}, 64'h0, 31'h0,
                               ANSWER_PREDICTED, ski_pkg::STATUS_DONE, 31'h0});
      directed_rows.push_back({ski_pkg::OP_LOOKUP, "ABC", "DEFGHIJK", 31'h0,
                               ANSWER_PREDICTED, ski_pkg::STATUS_DONE, 31'h0});
      directed_rows.push_back({ski_pkg::OP_INSERT, 24'h800000, 64'h8000000000000000,
                               31'h55555555,
                               ANSWER_PREDICTED, ski_pkg::STATUS_DONE, 31'h0});
      directed_rows.push_back({ski_pkg::OP_LOOKUP, 24'h7FFFFF, {64{1'b1}}, 31'h0,
                               ANSWER_PREDICTED, ski_pkg::STATUS_DONE, 31'h0});
      directed_rows.push_back({ski_pkg::OP_LOOKUP, 24'h800000, 64'h8000000000000000, 31'h0,
                               ANSWER_PREDICTED, ski_pkg::STATUS_DONE, 31'h0});
      directed_rows.push_back({ski_pkg::OP_LOOKUP, 24'hFFFFFF, 64'hFFFFFFFFFFFFFFFE, 31'h0,
                               ANSWER_PREDICTED, ski_pkg::STATUS_DONE, 31'h0});
      directed_rows.push_back({ski_pkg::OP_INSERT, 24'hFFFFFF, {64{1'b1}}, 31'h3,
                               ANSWER_PREDICTED, ski_pkg::STATUS_DONE, 31'h0});
      directed_rows.push_back({ski_pkg::OP_LOOKUP, 24'hFFFFFF, {64{1'b1}}, 31'h0,
                               ANSWER_PREDICTED, ski_pkg::STATUS_DONE, 31'h0});

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i])
         send_request(directed_rows[i].request, directed_rows[i].typed,
                      directed_rows[i].answer);
      settle();

      run_phase(0, 0, 1'b0, 100);
      run_phase(45, 0, 1'b0, 100);
      run_phase(0, 45, 1'b0, 100);
      // Fill to capacity, then search the full table and try to overfill it.
      run_phase(36, 36, 1'b1, 150);

      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Checked %0d answer beats: %0d inserts stored, %0d refused as full,",
               n_answers, n_stored, n_refused);
      $display("%0d lookups found and %0d missed; table reached %0d of %0d entries.",
               n_hits, n_misses, table_count, ski_pkg::CAPACITY);
      if (error_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
